// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define BTS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// a stalled item keeps its valid and payload
`define BTS_ASSERT_HOLD(label, vld, rdy, data, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		((vld) && !(rdy) |=> (vld) && $stable(data))) else $error(msg);

`endif

// ===== rtl/core/bts_pkg.sv =====
package bts_pkg;

	localparam int MAX_DIM_DEF   = 256;
	localparam int FRAC_BITS_DEF = 16;

	localparam int DIM_REG_W  = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int COORD_W    = 17;
	localparam int COORD_FRAC = 16;
	localparam int TEXEL_W    = 24;

	localparam logic [COORD_W-1:0]   COORD_ONE   = 17'h10000;
	localparam logic [DIM_REG_W-1:0] DIM_RESET   = 9'd256;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd1;
	localparam logic                 ACT_SAMPLE  = 1'b1;

	typedef struct packed {
		logic               action;
		logic [7:0]         texel_col;
		logic [7:0]         texel_row;
		logic [7:0]         write_red;
		logic [7:0]         write_green;
		logic [7:0]         write_blue;
		logic [COORD_W-1:0] coord_u;
		logic [COORD_W-1:0] coord_v;
	} in_item_t;

	typedef struct packed {
		logic [7:0] sample_red;
		logic [7:0] sample_green;
		logic [7:0] sample_blue;
	} out_item_t;

	typedef struct packed {
		logic valid;
		logic sample;
		logic wr_en;
	} stage_ctl_t;

endpackage

// ===== rtl/core/bts_coord.sv =====
module bts_coord #(
	parameter int MAX_DIM = bts_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = bts_pkg::FRAC_BITS_DEF,
	localparam int IDX_W = $clog2(MAX_DIM),
	localparam int ADDR_W = 2 * IDX_W
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  bts_pkg::in_item_t                req,
	input  logic [bts_pkg::DIM_REG_W-1:0]    tex_width,
	input  logic [bts_pkg::DIM_REG_W-1:0]    tex_height,
	input  logic                             fetch_ready,
	output bts_pkg::stage_ctl_t              ctl_s2,
	output logic [3:0][ADDR_W-1:0]           addr_s2,
	output logic [bts_pkg::TEXEL_W-1:0]      wdata_s2,
	output logic [FRAC_BITS-1:0]             fu_s2,
	output logic [FRAC_BITS-1:0]             fv_s2
);

	localparam int DIM_W = IDX_W + 1;
	localparam int CMP_W = (bts_pkg::DIM_REG_W > DIM_W) ? bts_pkg::DIM_REG_W : DIM_W;
	localparam int POS_W = bts_pkg::COORD_W + IDX_W;
	localparam int FW = (FRAC_BITS > bts_pkg::COORD_FRAC) ? FRAC_BITS : bts_pkg::COORD_FRAC;
	localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_DIM);

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [bts_pkg::DIM_REG_W-1:0] r);
		logic [CMP_W-1:0] x;
		x = CMP_W'(r);
		if (x == '0) begin
			x = CMP_W'(1);
		end else if (x > MAX_C) begin
			x = MAX_C;
		end
		return DIM_W'(x);
	endfunction

	function automatic logic [bts_pkg::COORD_W-1:0] clamp_coord(
		input logic [bts_pkg::COORD_W-1:0] c);
		return (c > bts_pkg::COORD_ONE) ? bts_pkg::COORD_ONE : c;
	endfunction

	function automatic logic [FRAC_BITS-1:0] widen_frac(input logic [POS_W-1:0] p);
		logic [FW-1:0] w;
		w = FW'(p[bts_pkg::COORD_FRAC-1:0]) << (FW - bts_pkg::COORD_FRAC);
		return w[FW-1 -: FRAC_BITS];
	endfunction

	bts_pkg::stage_ctl_t       ctl_d, ctl_s1;
	logic [DIM_W-1:0]          dim_u_d, dim_v_d;
	logic [IDX_W-1:0]          dm1_u, dm1_v;
	logic [POS_W-1:0]          pos_u_s1, pos_v_s1;
	logic [DIM_W-1:0]          dim_u_s1, dim_v_s1;
	logic [IDX_W-1:0]          col_s1, row_s1;
	logic [bts_pkg::TEXEL_W-1:0] wdata_s1;
	logic                      rdy2;
	logic [IDX_W-1:0]          iu, iv, iu1, iv1;
	logic [DIM_W-1:0]          nxt_u, nxt_v;
	logic [3:0][ADDR_W-1:0]    addr_d;

	assign rdy2 = !ctl_s2.valid || fetch_ready;
	assign req_ready = !ctl_s1.valid || rdy2;

	always_comb begin
		ctl_d.valid  = req_valid;
		ctl_d.sample = (req.action == bts_pkg::ACT_SAMPLE);
		ctl_d.wr_en  = (32'(req.texel_col) < 32'(MAX_DIM)) && (32'(req.texel_row) < 32'(MAX_DIM));
		dim_u_d = clamp_dim(tex_width);
		dim_v_d = clamp_dim(tex_height);
		dm1_u = IDX_W'(dim_u_d - DIM_W'(1));
		dm1_v = IDX_W'(dim_v_d - DIM_W'(1));
	end

	always_comb begin
		iu = pos_u_s1[bts_pkg::COORD_FRAC +: IDX_W];
		iv = pos_v_s1[bts_pkg::COORD_FRAC +: IDX_W];
		nxt_u = DIM_W'(iu) + DIM_W'(1);
		nxt_v = DIM_W'(iv) + DIM_W'(1);
		iu1 = (nxt_u == dim_u_s1) ? '0 : nxt_u[IDX_W-1:0];
		iv1 = (nxt_v == dim_v_s1) ? '0 : nxt_v[IDX_W-1:0];
		addr_d[0] = ctl_s1.sample ? {iv, iu} : {row_s1, col_s1};
		addr_d[1] = {iv, iu1};
		addr_d[2] = {iv1, iu};
		addr_d[3] = {iv1, iu1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			if (req_ready) begin
				ctl_s1 <= ctl_d;
			end
			if (rdy2) begin
				ctl_s2 <= ctl_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			pos_u_s1 <= POS_W'(clamp_coord(req.coord_u)) * POS_W'(dm1_u);
			pos_v_s1 <= POS_W'(clamp_coord(req.coord_v)) * POS_W'(dm1_v);
			dim_u_s1 <= dim_u_d;
			dim_v_s1 <= dim_v_d;
			col_s1   <= IDX_W'(req.texel_col);
			row_s1   <= IDX_W'(req.texel_row);
			wdata_s1 <= {req.write_red, req.write_green, req.write_blue};
		end
		if (rdy2 && ctl_s1.valid) begin
			addr_s2  <= addr_d;
			wdata_s2 <= wdata_s1;
			fu_s2    <= widen_frac(pos_u_s1);
			fv_s2    <= widen_frac(pos_v_s1);
		end
	end

endmodule

// ===== rtl/core/bts_fetch.sv =====
module bts_fetch #(
	parameter int MAX_DIM = bts_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = bts_pkg::FRAC_BITS_DEF,
	localparam int IDX_W = $clog2(MAX_DIM),
	localparam int ADDR_W = 2 * IDX_W
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bts_pkg::stage_ctl_t                   ctl_s2,
	input  logic [3:0][ADDR_W-1:0]                addr_s2,
	input  logic [bts_pkg::TEXEL_W-1:0]           wdata_s2,
	input  logic [FRAC_BITS-1:0]                  fu_s2,
	input  logic [FRAC_BITS-1:0]                  fv_s2,
	output logic                                  fetch_ready,
	input  logic                                  blend_ready,
	output logic                                  valid_s3,
	output logic [3:0][bts_pkg::TEXEL_W-1:0]      texel_s3,
	output logic [FRAC_BITS-1:0]                  fu_s3,
	output logic [FRAC_BITS-1:0]                  fv_s3
);

	localparam int DEPTH = 1 << ADDR_W;

	// two copies of the store, each with one write and two read ports
	logic [bts_pkg::TEXEL_W-1:0] mem_a [DEPTH];
	logic [bts_pkg::TEXEL_W-1:0] mem_b [DEPTH];

	assign fetch_ready = !valid_s3 || blend_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (fetch_ready) begin
			valid_s3 <= ctl_s2.valid && ctl_s2.sample;
		end
	end

	always_ff @(posedge clk) begin
		if (fetch_ready && ctl_s2.valid) begin
			if (!ctl_s2.sample && ctl_s2.wr_en) begin
				mem_a[addr_s2[0]] <= wdata_s2;
				mem_b[addr_s2[0]] <= wdata_s2;
			end
			if (ctl_s2.sample) begin
				texel_s3[0] <= mem_a[addr_s2[0]];
				texel_s3[1] <= mem_a[addr_s2[1]];
				texel_s3[2] <= mem_b[addr_s2[2]];
				texel_s3[3] <= mem_b[addr_s2[3]];
				fu_s3 <= fu_s2;
				fv_s3 <= fv_s2;
			end
		end
	end

endmodule

// ===== rtl/core/bts_blend.sv =====
module bts_blend #(
	parameter int FRAC_BITS = bts_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_s3,
	input  logic [3:0][bts_pkg::TEXEL_W-1:0]  texel_s3,
	input  logic [FRAC_BITS-1:0]              fu_s3,
	input  logic [FRAC_BITS-1:0]              fv_s3,
	output logic                              blend_ready,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output bts_pkg::out_item_t                rsp
);

	localparam int LW = FRAC_BITS + 8;
	localparam int AW = 2 * FRAC_BITS + 8;
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic                      valid_s4;
	logic [2:0][LW-1:0]        left_s4, right_s4, left_d, right_d;
	logic [FRAC_BITS-1:0]      fu_s4;
	logic [FRAC_BITS:0]        one_m_fv, one_m_fu;
	logic [2:0][AW-1:0]        acc;
	logic [2:0][7:0]           chan;
	logic                      rdy5;

	assign rdy5 = !rsp_valid || rsp_ready;
	assign blend_ready = !valid_s4 || rdy5;

	// column blend by the v weight
	always_comb begin
		one_m_fv = ONE - (FRAC_BITS+1)'(fv_s3);
		for (int c = 0; c < 3; c++) begin
			left_d[c]  = LW'(texel_s3[0][8*c +: 8]) * LW'(one_m_fv)
				+ LW'(texel_s3[2][8*c +: 8]) * LW'(fv_s3);
			right_d[c] = LW'(texel_s3[1][8*c +: 8]) * LW'(one_m_fv)
				+ LW'(texel_s3[3][8*c +: 8]) * LW'(fv_s3);
		end
	end

	// row blend by the u weight, round half up
	always_comb begin
		one_m_fu = ONE - (FRAC_BITS+1)'(fu_s4);
		for (int c = 0; c < 3; c++) begin
			acc[c]  = AW'(left_s4[c]) * AW'(one_m_fu) + AW'(right_s4[c]) * AW'(fu_s4);
			chan[c] = acc[c][2*FRAC_BITS +: 8] + 8'(acc[c][2*FRAC_BITS-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4  <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (blend_ready) begin
				valid_s4 <= valid_s3;
			end
			if (rdy5) begin
				rsp_valid <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (blend_ready && valid_s3) begin
			left_s4  <= left_d;
			right_s4 <= right_d;
			fu_s4    <= fu_s3;
		end
		if (rdy5 && valid_s4) begin
			rsp.sample_red   <= chan[2];
			rsp.sample_green <= chan[1];
			rsp.sample_blue  <= chan[0];
		end
	end

endmodule

// ===== rtl/core/bilinear_texture_sampler_core.sv =====
// bilinear texture sampler, five register stages
// a sample item passes s1, s2, s3, s4 and the output register in order
// throughput: one item per cycle unless stalled, write or sample; the
// texel store is duplicated so the four neighbor reads register at once
// reset clears all stage valid bits and sets width and height to 256;
// the texel store is not cleared and reads as undefined until written
module bilinear_texture_sampler_core #(
	parameter int MAX_DIM = bts_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = bts_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  bts_pkg::in_item_t                 req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output bts_pkg::out_item_t                rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bts_pkg::DIM_REG_W-1:0]     cfg_data
);

	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int ADDR_W = 2 * IDX_W;

	logic [bts_pkg::DIM_REG_W-1:0]        tex_width_q, tex_height_q;
	bts_pkg::stage_ctl_t                  ctl_s2;
	logic [3:0][ADDR_W-1:0]               addr_s2;
	logic [bts_pkg::TEXEL_W-1:0]          wdata_s2;
	logic [FRAC_BITS-1:0]                 fu_s2, fv_s2, fu_s3, fv_s3;
	logic                                 fetch_ready, blend_ready, valid_s3;
	logic [3:0][bts_pkg::TEXEL_W-1:0]     texel_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= bts_pkg::DIM_RESET;
			tex_height_q <= bts_pkg::DIM_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				bts_pkg::CFG_WIDTH: begin
					tex_width_q <= cfg_data;
				end
				bts_pkg::CFG_HEIGHT: begin
					tex_height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	bts_coord #(
		.MAX_DIM   (MAX_DIM),
		.FRAC_BITS (FRAC_BITS)
	) u_coord (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.tex_width   (tex_width_q),
		.tex_height  (tex_height_q),
		.fetch_ready (fetch_ready),
		.ctl_s2      (ctl_s2),
		.addr_s2     (addr_s2),
		.wdata_s2    (wdata_s2),
		.fu_s2       (fu_s2),
		.fv_s2       (fv_s2)
	);

	bts_fetch #(
		.MAX_DIM   (MAX_DIM),
		.FRAC_BITS (FRAC_BITS)
	) u_fetch (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl_s2      (ctl_s2),
		.addr_s2     (addr_s2),
		.wdata_s2    (wdata_s2),
		.fu_s2       (fu_s2),
		.fv_s2       (fv_s2),
		.fetch_ready (fetch_ready),
		.blend_ready (blend_ready),
		.valid_s3    (valid_s3),
		.texel_s3    (texel_s3),
		.fu_s3       (fu_s3),
		.fv_s3       (fv_s3)
	);

	bts_blend #(
		.FRAC_BITS (FRAC_BITS)
	) u_blend (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s3    (valid_s3),
		.texel_s3    (texel_s3),
		.fu_s3       (fu_s3),
		.fv_s3       (fv_s3),
		.blend_ready (blend_ready),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp)
	);

endmodule

// ===== rtl/core/bts_checker.sv =====
`include "assert_macros.svh"

module bts_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input bts_pkg::in_item_t              req,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input bts_pkg::out_item_t             rsp,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [bts_pkg::DIM_REG_W-1:0]  cfg_data
);

	// a draining or empty output never backs up the input
	`BTS_ASSERT(a_drain_ready, (rsp_ready || !rsp_valid) |-> req_ready, "input stalled while output drains")
	// configuration writes are never stalled
	`BTS_ASSERT(a_cfg_ready, cfg_ready, "configuration port not ready")
	// the pipeline shows no result while the delayed copy of reset taken by $past is still asserted
	`BTS_ASSERT(a_reset_empty, !$past(arst_n, 4) |-> !rsp_valid, "result too soon after reset")
	`BTS_ASSERT_HOLD(a_rsp_hold, rsp_valid, rsp_ready, rsp, "stalled result item changed")

endmodule

bind bilinear_texture_sampler_core bts_checker u_bts_checker (.*);
